// ===== sv/cpsb_pkg.sv =====
// Shared types and constants for the column post sprite blitter.
`default_nettype none

package cpsb_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MAP     = 3'd4;

  // Screen coordinates carry the sum of a 9-bit origin and a 9-bit offset (the y origin is 8 bits).
  localparam int COORD_W = 10;

  // Top-row byte that closes a column.
  localparam logic [7:0] END_OF_COLUMN = 8'hff;

  // Live configuration.
  typedef struct packed {
    logic [8:0] origin_x;
    logic [7:0] origin_y;
    logic [8:0] patch_width;
    logic       mirror;
    logic       use_map;
  } cfg_t;

  // One on-screen pixel leaving the parser.
  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [7:0]         raw;
    logic               use_map;
  } pix_t;

  // One framebuffer write.
  typedef struct packed {
    logic [15:0] pixel_address;
    logic [7:0]  pixel_value;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/cpsb_if.sv =====
// Handshake channel interfaces for stream bytes, pixel writes and configuration.
`default_nettype none

interface cpsb_stream_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       column_start;
  logic [8:0] source_column;
  logic [7:0] data_byte;
  logic [7:0] map_index;

  modport source (output valid, func, column_start, source_column, data_byte, map_index,
                  input ready);
  modport sink (input valid, func, column_start, source_column, data_byte, map_index,
                output ready);
endinterface

interface cpsb_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_address;
  logic [7:0]  pixel_value;

  modport source (output valid, pixel_address, pixel_value, input ready);
  modport sink (input valid, pixel_address, pixel_value, output ready);
endinterface

interface cpsb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/column_post_sprite_blitter_unit.sv =====
// Top level of the column post sprite blitter.
`default_nettype none

// Takes one beat per clock on the stream channel while it is not stalled: column
// post-list bytes (func 0) or colour map writes (func 1). Each pixel byte that lands on
// screen yields one beat on the pixels channel, after passing through the parser's pixel
// register (with the colour map read register beside it) and a two-entry output stage;
// other bytes yield nothing. The stream channel keeps accepting a beat every cycle unless
// the pixel register is occupied and both output entries are full. Configuration writes
// are taken at any time and should be issued only while the block is idle.
module column_post_sprite_blitter_unit
  import cpsb_pkg::*;
#(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  wire logic    clk,
  input  wire logic    rst,
  cpsb_stream_if.sink  stream,
  cpsb_pixel_if.source pixels,
  cpsb_cfg_if.sink     cfg
);

  localparam int PROD_W = COORD_W + $clog2(SCREEN_WIDTH + 1);

  cfg_t        cfg_q;
  logic        load, take, drain;
  logic        pix_valid;
  pix_t        pix;
  logic        rd_en;
  logic [7:0]  map_value;
  logic        skid_ready;
  res_t        res;
  logic [PROD_W-1:0] row_base;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.origin_x <= 9'd0;
      cfg_q.origin_y <= 8'd0;
      cfg_q.patch_width <= 9'd1;
      cfg_q.mirror <= 1'b0;
      cfg_q.use_map <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ORIGIN_X: cfg_q.origin_x <= cfg.data;
        CFG_ORIGIN_Y: cfg_q.origin_y <= cfg.data[7:0];
        CFG_PATCH_WIDTH: cfg_q.patch_width <= cfg.data;
        CFG_MIRROR: cfg_q.mirror <= cfg.data[0];
        CFG_USE_MAP: cfg_q.use_map <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Stream handshake.
  assign stream.ready = !pix_valid || skid_ready;
  assign load = stream.valid && stream.ready;
  assign take = load && !stream.func;
  assign drain = pix_valid && skid_ready;

  cpsb_parse #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_q),
    .load(load),
    .take(take),
    .column_start(stream.column_start),
    .source_column(stream.source_column),
    .data_byte(stream.data_byte),
    .drain(drain),
    .pix_valid(pix_valid),
    .pix(pix),
    .rd_en(rd_en)
  );

  cpsb_cmap u_cmap (
    .clk(clk),
    .wr_en(load && stream.func),
    .wr_index(stream.map_index),
    .wr_data(stream.data_byte),
    .rd_en(rd_en),
    .rd_index(stream.data_byte),
    .rd_data(map_value)
  );

  // Framebuffer address and final pixel value.
  assign row_base = PROD_W'(pix.sy) * PROD_W'(SCREEN_WIDTH);
  assign res.pixel_address = 16'(row_base + PROD_W'(pix.sx));
  assign res.pixel_value = pix.use_map ? map_value : pix.raw;

  cpsb_skid u_skid (
    .clk(clk),
    .rst(rst),
    .in_valid(pix_valid),
    .in_ready(skid_ready),
    .in_data(res),
    .pixels(pixels)
  );

endmodule

`default_nettype wire

// ===== sv/cpsb_cmap.sv =====
// Colour map store: 256 entries of 8 bits, one write port, one registered read port.
`default_nettype none

module cpsb_cmap (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_index,
  input  wire logic [7:0] wr_data,
  input  wire logic       rd_en,
  input  wire logic [7:0] rd_index,
  output logic      [7:0] rd_data
);

  logic [7:0] mem [256];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_index] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_index];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cpsb_parse.sv =====
// Post list parser: walks the column byte stream and registers on-screen pixels.
`default_nettype none

module cpsb_parse
  import cpsb_pkg::*;
#(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       load,
  input  wire logic       take,
  input  wire logic       column_start,
  input  wire logic [8:0] source_column,
  input  wire logic [7:0] data_byte,
  input  wire logic       drain,
  output logic            pix_valid,
  output pix_t            pix,
  output logic            rd_en
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TOP  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_PAD1 = 3'd3;
  localparam logic [2:0] PH_PIX  = 3'd4;
  localparam logic [2:0] PH_PAD2 = 3'd5;

  logic [2:0] phase, phase_next, phase_eff;
  logic [8:0] post_row, post_row_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [8:0] dest_column, dest_column_next;
  logic [7:0] left_dec;
  logic [COORD_W-1:0] sx, sy;
  logic on_screen;
  logic hit;

  // A column start reloads the destination column and restarts at a top-row byte.
  always_comb begin
    phase_eff = phase;
    dest_column_next = dest_column;
    if (column_start) begin
      phase_eff = PH_TOP;
      if (cfg.mirror) begin
        dest_column_next = cfg.patch_width - 9'd1 - source_column;
      end else begin
        dest_column_next = source_column;
      end
    end
  end

  // Screen position and bounds of the pixel this byte would draw.
  assign sx = COORD_W'(cfg.origin_x) + COORD_W'(dest_column_next);
  assign sy = COORD_W'(cfg.origin_y) + COORD_W'(post_row);
  assign on_screen = ({1'b0, sx} < 11'(SCREEN_WIDTH)) && ({1'b0, sy} < 11'(SCREEN_HEIGHT));
  assign left_dec = bytes_left - 8'd1;

  // Parse step for one stream byte.
  always_comb begin
    phase_next = phase_eff;
    post_row_next = post_row;
    bytes_left_next = bytes_left;
    hit = 1'b0;
    case (phase_eff)
      PH_TOP: begin
        if (data_byte == END_OF_COLUMN) begin
          phase_next = PH_IDLE;
        end else begin
          post_row_next = {1'b0, data_byte};
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_left_next = data_byte;
        phase_next = PH_PAD1;
      end
      PH_PAD1: begin
        phase_next = (bytes_left == 8'd0) ? PH_PAD2 : PH_PIX;
      end
      PH_PIX: begin
        hit = on_screen;
        post_row_next = post_row + 9'd1;
        bytes_left_next = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_PAD2;
        end
      end
      PH_PAD2: begin
        phase_next = PH_TOP;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign rd_en = take && hit;

  // Parse state advances on every accepted post-list byte (func 0).
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      post_row <= '0;
      bytes_left <= '0;
      dest_column <= '0;
    end else if (take) begin
      phase <= phase_next;
      post_row <= post_row_next;
      bytes_left <= bytes_left_next;
      dest_column <= dest_column_next;
    end
  end

  // Pixel register between the parser and the output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (load) begin
      pix_valid <= rd_en;
    end else if (drain) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pix.sx <= sx;
      pix.sy <= sy;
      pix.raw <= data_byte;
      pix.use_map <= cfg.use_map;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cpsb_skid.sv =====
// Output register with a skid entry so the upstream ready comes from a register, not from the output ready.
`default_nettype none

module cpsb_skid
  import cpsb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire res_t     in_data,
  cpsb_pixel_if.source  pixels
);

  logic out_valid;
  res_t out_data;
  logic sk_valid;
  res_t sk_data;

  assign in_ready = !sk_valid;
  assign pixels.valid = out_valid;
  assign pixels.pixel_address = out_data.pixel_address;
  assign pixels.pixel_value = out_data.pixel_value;

  // Control: refill the output from the skid entry first, else from the input.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!out_valid || pixels.ready) begin
      if (sk_valid) begin
        sk_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      sk_valid <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (!out_valid || pixels.ready) begin
      out_data <= sk_valid ? sk_data : in_data;
    end else if (in_valid && !sk_valid) begin
      sk_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cpsb_checker.sv =====
// Port-level checks for the blitter and the bind that attaches them.
`default_nettype none

module cpsb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_ready,
  input wire logic        p_valid,
  input wire logic        p_ready,
  input wire logic [15:0] p_address,
  input wire logic [7:0]  p_value
);

  // A pending pixel beat stays offered until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_ready |=> p_valid)
    else $error("pixel beat withdrawn while stalled");

  // A stalled pixel beat keeps its payload.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_ready |=> $stable(p_address) && $stable(p_value))
    else $error("pixel payload changed while stalled");

  // The stream side only stalls when results are backed up at the output.
  a_backlog: assert property (@(posedge clk) disable iff (rst)
    !s_ready |-> p_valid)
    else $error("stream stalled with no pixel pending");

  // Reset empties the pipeline and opens the stream side.
  a_reset: assert property (@(posedge clk)
    rst |=> !p_valid && s_ready)
    else $error("pipeline not empty after reset");

endmodule

bind column_post_sprite_blitter_unit cpsb_checker u_checker (
  .clk(clk),
  .rst(rst),
  .s_ready(stream.ready),
  .p_valid(pixels.valid),
  .p_ready(pixels.ready),
  .p_address(pixels.pixel_address),
  .p_value(pixels.pixel_value)
);

`default_nettype wire

// ===== tb/sv/blit_tb_pkg.sv =====
// Codes shared by the blitter testbench and its checker.
package blit_tb_pkg;

  // Meaning of the func bit on the stream channel.
  typedef enum logic {
    FUNC_STREAM = 1'b0,
    FUNC_MAP    = 1'b1
  } func_e;

endpackage

// ===== tb/sv/pixel_write_checker.sv =====
// Checker that predicts the framebuffer writes of the blitter and compares them.
module pixel_write_checker
  import cpsb_pkg::*;
  import blit_tb_pkg::*;
#(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic   clk,
  input  logic   rst,
  cpsb_stream_if stream,
  cpsb_pixel_if  pixels,
  cpsb_cfg_if    cfg,
  output int     pending,
  output int     errors
);
  timeunit 1ns;
  timeprecision 1ps;

  // Where the parser stands within a column's post list.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TOP,
    SCAN_LENGTH,
    SCAN_PAD_HEAD,
    SCAN_PIXELS,
    SCAN_PAD_TAIL
  } scan_e;

  cfg_t       regs;
  scan_e      scan;
  logic [8:0] row;
  logic [7:0] run_left;
  logic [8:0] dest_col;
  logic [7:0] shade_map [256];
  res_t       expected_writes [$];
  int         fail_total;

  initial begin
    pending = 0;
    errors = 0;
    fail_total = 0;
    for (int i = 0; i < 256; i++) begin
      shade_map[i] = 8'd0;
    end
  end

  // Advances the parser by one beat; returns 1 when the beat draws a visible pixel.
  function automatic bit predict_pixel_write(input logic fn, input logic st,
                                             input logic [8:0] src, input logic [7:0] data,
                                             input logic [7:0] idx, output res_t wr);
    int sx;
    int sy;
    bit hit;
    logic [31:0] addr;
    hit = 1'b0;
    wr = '0;
    if (fn == FUNC_MAP) begin
      shade_map[idx] = data;
      return 1'b0;
    end
    if (st) begin
      dest_col = regs.mirror ? 9'(regs.patch_width - 9'd1 - src) : src;
      scan = SCAN_TOP;
    end
    case (scan)
      SCAN_TOP: begin
        if (data == END_OF_COLUMN) begin
          scan = SCAN_IDLE;
        end else begin
          row = {1'b0, data};
          scan = SCAN_LENGTH;
        end
      end
      SCAN_LENGTH: begin
        run_left = data;
        scan = SCAN_PAD_HEAD;
      end
      SCAN_PAD_HEAD: begin
        scan = (run_left == 8'd0) ? SCAN_PAD_TAIL : SCAN_PIXELS;
      end
      SCAN_PIXELS: begin
        sx = int'(regs.origin_x) + int'(dest_col);
        sy = int'(regs.origin_y) + int'(row);
        if (sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT) begin
          addr = 32'(sy * SCREEN_WIDTH + sx);
          wr.pixel_address = addr[15:0];
          wr.pixel_value = regs.use_map ? shade_map[data] : data;
          hit = 1'b1;
        end
        row = row + 9'd1;
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) begin
          scan = SCAN_PAD_TAIL;
        end
      end
      SCAN_PAD_TAIL: begin
        scan = SCAN_TOP;
      end
      default: begin
        scan = SCAN_IDLE;
      end
    endcase
    return hit;
  endfunction

  // Track configuration and stream beats, then match pixel beats in order.
  always @(posedge clk) begin
    res_t wr;
    res_t want;
    if (rst) begin
      regs = '{origin_x: 9'd0, origin_y: 8'd0, patch_width: 9'd1, mirror: 1'b0,
               use_map: 1'b0};
      scan = SCAN_IDLE;
      row = 9'd0;
      run_left = 8'd0;
      dest_col = 9'd0;
      expected_writes.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_ORIGIN_X:    regs.origin_x = cfg.data;
          CFG_ORIGIN_Y:    regs.origin_y = cfg.data[7:0];
          CFG_PATCH_WIDTH: regs.patch_width = cfg.data;
          CFG_MIRROR:      regs.mirror = cfg.data[0];
          CFG_USE_MAP:     regs.use_map = cfg.data[0];
          default: ;
        endcase
      end
      if (stream.valid && stream.ready) begin
        if (predict_pixel_write(stream.func, stream.column_start, stream.source_column,
                                stream.data_byte, stream.map_index, wr)) begin
          expected_writes.push_back(wr);
        end
      end
      if (pixels.valid && pixels.ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected pixel write: expected none, actual addr %0d value %0d",
                   $time, pixels.pixel_address, pixels.pixel_value);
          fail_total++;
        end else begin
          want = expected_writes.pop_front();
          if (pixels.pixel_address !== want.pixel_address) begin
            $display("%0t: pixel_address mismatch: expected %0d, actual %0d",
                     $time, want.pixel_address, pixels.pixel_address);
            fail_total++;
          end
          if (pixels.pixel_value !== want.pixel_value) begin
            $display("%0t: pixel_value mismatch: expected %0d, actual %0d",
                     $time, want.pixel_value, pixels.pixel_value);
            fail_total++;
          end
        end
      end
    end
    pending <= expected_writes.size();
    errors <= fail_total;
  end

endmodule

// ===== tb/sv/column_post_sprite_blitter_unit_tb.sv =====
// Testbench top: drives column streams, map loads and settings into the blitter.
module column_post_sprite_blitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpsb_pkg::*;
  import blit_tb_pkg::*;

  localparam int SCREEN_WIDTH = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int ITEM_TARGET = 550;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_req = 1'b0;
  bit   hold_done;

  cpsb_stream_if stream_bus ();
  cpsb_pixel_if  pixel_bus ();
  cpsb_cfg_if    cfg_bus ();

  int writes_pending;
  int check_errors;
  int items_sent;
  int burst_left;
  int idle_cycles;
  bit map_loaded [256];
  bit shade_on;
  bit cur_mirror;
  int cur_width;

  column_post_sprite_blitter_unit #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .stream(stream_bus),
    .pixels(pixel_bus),
    .cfg   (cfg_bus)
  );

  pixel_write_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_check (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_bus),
    .pixels (pixel_bus),
    .cfg    (cfg_bus),
    .pending(writes_pending),
    .errors (check_errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Picks the low end, the high end or anything in between.
  function automatic int pick_extreme(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Offers one beat on the stream channel, with bursts and random gaps.
  task automatic put_beat(input func_e fn, input logic st, input logic [8:0] col,
                          input logic [7:0] data, input logic [7:0] idx, input bit counted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 20);
      if (gap != 0) begin
        stream_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    stream_bus.valid <= 1'b1;
    stream_bus.func <= fn;
    stream_bus.column_start <= st;
    stream_bus.source_column <= col;
    stream_bus.data_byte <= data;
    stream_bus.map_index <= idx;
    do @(posedge clk); while (!stream_bus.ready);
    if (fn == FUNC_MAP) map_loaded[idx] = 1'b1;
    if (counted) items_sent++;
  endtask

  // Sends a column byte; with translation on, an unloaded map entry is loaded first.
  task automatic put_stream_byte(input logic st, input logic [8:0] col,
                                 input logic [7:0] data, input bit counted);
    if (shade_on && !map_loaded[data]) begin
      put_beat(FUNC_MAP, 1'b0, col, 8'($urandom_range(0, 255)), data, 1'b1);
    end
    put_beat(FUNC_STREAM, st, col, data, 8'($urandom_range(0, 255)), counted);
  endtask

  // Sends a byte sequence as one column, marking its first byte as the start.
  task automatic play_bytes(input logic [8:0] col, input logic [7:0] seq[$]);
    foreach (seq[i]) begin
      put_stream_byte(i == 0, col, seq[i], 1'b1);
    end
  endtask

  // Writes every register back to back; only called while the block is idle.
  task automatic set_config(input logic [8:0] ox, input logic [7:0] oy, input logic [8:0] pw,
                            input logic mir, input logic um);
    logic [2:0] idxs [5];
    logic [8:0] vals [5];
    idxs = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_PATCH_WIDTH, CFG_MIRROR, CFG_USE_MAP};
    vals = '{ox, {1'b0, oy}, pw, {8'd0, mir}, {8'd0, um}};
    for (int i = 0; i < 5; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idxs[i];
      cfg_bus.data <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
    shade_on = um;
    cur_mirror = mir;
    cur_width = int'(pw);
  endtask

  // Stops sending and waits until every predicted write is out and the pipe is empty.
  task automatic quiesce();
    stream_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (writes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Builds a random post list; a broken column is cut short before its end.
  task automatic send_column(input bit broken);
    logic [7:0] seq [$];
    logic [7:0] cut_seq [$];
    logic [8:0] col;
    int posts;
    int len;
    int r;
    int cut;
    if (cur_mirror && $urandom_range(0, 1)) col = 9'($urandom_range(0, cur_width - 1));
    else col = 9'($urandom_range(0, 319));
    posts = $urandom_range(0, 3);
    for (int p = 0; p < posts; p++) begin
      if ($urandom_range(0, 9) == 0) seq.push_back(8'($urandom_range(200, 254)));
      else seq.push_back(8'($urandom_range(0, 199)));
      r = $urandom_range(0, 49);
      if (r < 35) len = $urandom_range(0, 8);
      else if (r < 48) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 255);
      seq.push_back(8'(len));
      seq.push_back(8'($urandom_range(0, 255)));
      repeat (len) seq.push_back(8'($urandom_range(0, 255)));
      seq.push_back(8'($urandom_range(0, 255)));
    end
    seq.push_back(END_OF_COLUMN);
    if (broken && seq.size() > 1) begin
      cut = $urandom_range(1, seq.size() - 1);
      for (int i = 0; i < cut; i++) cut_seq.push_back(seq[i]);
      play_bytes(col, cut_seq);
    end else begin
      play_bytes(col, seq);
    end
  endtask

  // Output side: random ready patterns, plus one long hold-off on request.
  initial begin
    int mode;
    int span;
    pixel_bus.ready = 1'b0;
    hold_done = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        pixel_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
      end
      span--;
      case (mode)
        0: pixel_bus.ready <= 1'b1;
        1: pixel_bus.ready <= ($urandom_range(0, 3) != 0);
        2: pixel_bus.ready <= ($urandom_range(0, 3) == 0);
        default: pixel_bus.ready <= ~pixel_bus.ready;
      endcase
    end
  end

  // Watchdog: ends the run when no channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((stream_bus.valid && stream_bus.ready) || (pixel_bus.valid && pixel_bus.ready)
                 || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus: directed cases, a back-pressure phase, then random phases.
  initial begin
    logic [7:0] script [$];
    int kind;
    stream_bus.valid = 1'b0;
    stream_bus.func = FUNC_STREAM;
    stream_bus.column_start = 1'b0;
    stream_bus.source_column = 9'd0;
    stream_bus.data_byte = 8'd0;
    stream_bus.map_index = 8'd0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_ORIGIN_X;
    cfg_bus.data = 9'd0;
    items_sent = 0;
    burst_left = 0;
    shade_on = 1'b0;
    cur_mirror = 1'b0;
    cur_width = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A stray byte with no open column, then a column at the right screen edge with
    // a post running off the bottom, a zero length post and the end mark.
    set_config(9'd0, 8'd0, 9'd320, 1'b0, 1'b0);
    put_stream_byte(1'b0, 9'd4, 8'h12, 1'b0);
    script = '{8'd199, 8'd2, 8'h00, 8'h00, 8'hff, 8'h00, 8'd7, 8'd0, 8'h00, 8'h00,
               END_OF_COLUMN};
    play_bytes(9'd319, script);
    // A new column start in the middle of a post abandons it.
    script = '{8'd0, 8'd3, 8'h00, 8'h5a};
    play_bytes(9'd2, script);
    put_stream_byte(1'b1, 9'd1, END_OF_COLUMN, 1'b1);
    quiesce();

    // Highest origin, mirrored narrow patch and a translated pixel.
    set_config(9'd319, 8'd199, 9'd1, 1'b1, 1'b1);
    put_beat(FUNC_MAP, 1'b0, 9'd0, 8'hc3, 8'h3c, 1'b1);
    script = '{8'd0, 8'd1, 8'h00, 8'h3c, 8'h00, END_OF_COLUMN};
    play_bytes(9'd0, script);
    quiesce();

    // Long post while the output side holds off, so the input side backs up.
    set_config(9'd0, 8'd0, 9'd320, 1'b0, 1'b0);
    hold_req <= 1'b1;
    script = '{8'd0, 8'd60, 8'h00};
    repeat (60) script.push_back(8'($urandom_range(0, 255)));
    script.push_back(8'h00);
    script.push_back(END_OF_COLUMN);
    play_bytes(9'd100, script);
    quiesce();

    // Random phases: mostly whole columns, some cut short, some stray beats.
    while (items_sent < ITEM_TARGET) begin
      set_config(9'(pick_extreme(0, 319)), 8'(pick_extreme(0, 199)),
                 9'(pick_extreme(1, 320)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          send_column(1'b0);
        end else if (kind == 8) begin
          send_column(1'b1);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) begin
              put_beat(FUNC_MAP, 1'b0, 9'($urandom_range(0, 319)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
            end else begin
              put_stream_byte(1'b0, 9'($urandom_range(0, 319)),
                              8'($urandom_range(0, 255)), 1'b0);
            end
          end
        end
      end
      quiesce();
    end

    if (check_errors == 0 && writes_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
